/* rtl/edbl_pkg.sv */
// ---------------------------------------------------------------------------
// Edge deblocking line filter package
// Shared beat types, register indexes and reset values.
// ---------------------------------------------------------------------------
package edbl_pkg;

	localparam int PIX_W          = 16;
	localparam int SAMPLE_BITS_DF = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 3'd4;

	localparam logic [15:0] ALPHA_RST = 16'd13;
	localparam logic [12:0] BETA_RST  = 13'd4;
	localparam logic [13:0] CLIP_RST  = 14'd1;
	localparam logic [8:0]  STEP_RST  = 9'd1;
	localparam logic [15:0] PEAK_RST  = 16'd255;

	typedef struct packed {
		logic [PIX_W-1:0] p2_in;
		logic [PIX_W-1:0] p1_in;
		logic [PIX_W-1:0] p0_in;
		logic [PIX_W-1:0] q0_in;
		logic [PIX_W-1:0] q1_in;
		logic [PIX_W-1:0] q2_in;
	} pix_line_t;

	typedef struct packed {
		logic [PIX_W-1:0] p1_out;
		logic [PIX_W-1:0] p0_out;
		logic [PIX_W-1:0] q0_out;
		logic [PIX_W-1:0] q1_out;
		logic             was_filtered;
	} pix_result_t;

	typedef struct packed {
		logic [15:0] alpha_threshold;
		logic [12:0] beta_threshold;
		logic [13:0] base_clip;
		logic [8:0]  clip_step;
		logic [15:0] pixel_peak;
	} edbl_cfg_t;

endpackage

/* rtl/edbl_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Edge deblocking configuration registers
// Holds the thresholds, clip bounds and pixel peak written over the cfg port.
// ---------------------------------------------------------------------------
module edbl_cfg_regs import edbl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output edbl_cfg_t             cfg
);

	edbl_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_threshold <= ALPHA_RST;
			cfg_q.beta_threshold  <= BETA_RST;
			cfg_q.base_clip       <= CLIP_RST;
			cfg_q.clip_step       <= STEP_RST;
			cfg_q.pixel_peak      <= PEAK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ALPHA: cfg_q.alpha_threshold <= cfg_data[15:0];
				REG_BETA:  cfg_q.beta_threshold  <= cfg_data[12:0];
				REG_CLIP:  cfg_q.base_clip       <= cfg_data[13:0];
				REG_STEP:  cfg_q.clip_step       <= cfg_data[8:0];
				REG_PEAK:  cfg_q.pixel_peak      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/edbl_filter.sv */
// ---------------------------------------------------------------------------
// Edge deblocking filter datapath
// Combinational normal-mode filter for one six-pixel line across an edge.
// ---------------------------------------------------------------------------
module edbl_filter import edbl_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DF
) (
	input  pix_line_t   line,
	input  edbl_cfg_t   cfg,
	output pix_result_t res
);

	localparam logic [PIX_W-1:0] SAMPLE_MASK = PIX_W'((33'd1 << SAMPLE_BITS) - 33'd1);

	function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Clip a signed value to +/- an unsigned bound.
	function automatic logic signed [20:0] clip_sym(input logic signed [20:0] v,
		input logic [14:0] lim);
		logic signed [20:0] l;
		l = 21'(signed'({1'b0, lim}));
		if (v > l)
			return l;
		else if (v < -l)
			return -l;
		return v;
	endfunction

	function automatic logic signed [20:0] sx(input logic [PIX_W-1:0] v);
		return 21'(signed'({1'b0, v}));
	endfunction

	logic [PIX_W-1:0]   p2, p1, p0, q0, q1, q2;
	logic [PIX_W-1:0]   peak;
	logic               edge_ok, p_side, q_side;
	logic [14:0]        c;
	logic [16:0]        avg_sum;
	logic [PIX_W-1:0]   avg;
	logic signed [20:0] num, quo, delta, p0n, q0n;
	logic signed [20:0] tp, tq, hp, hq, p1n, q1n;
	logic [PIX_W-1:0]   p0c, q0c;

	always_comb begin
		p2 = line.p2_in & SAMPLE_MASK;
		p1 = line.p1_in & SAMPLE_MASK;
		p0 = line.p0_in & SAMPLE_MASK;
		q0 = line.q0_in & SAMPLE_MASK;
		q1 = line.q1_in & SAMPLE_MASK;
		q2 = line.q2_in & SAMPLE_MASK;
		peak = (cfg.pixel_peak > SAMPLE_MASK) ? SAMPLE_MASK : cfg.pixel_peak;

		edge_ok = (absdiff(p0, q0) < cfg.alpha_threshold)
			&& (absdiff(p1, p0) < {3'b000, cfg.beta_threshold})
			&& (absdiff(q1, q0) < {3'b000, cfg.beta_threshold});
		p_side = absdiff(p2, p0) < {3'b000, cfg.beta_threshold};
		q_side = absdiff(q2, q0) < {3'b000, cfg.beta_threshold};

		c = {1'b0, cfg.base_clip} + (p_side ? {6'd0, cfg.clip_step} : 15'd0)
			+ (q_side ? {6'd0, cfg.clip_step} : 15'd0);

		// The shift floors, so negative values are biased first to round toward zero.
		num   = (sx(q0) - sx(p0)) * 21'sd4 + sx(p1) - sx(q1) + 21'sd4;
		quo   = (num + ((num < 0) ? 21'sd7 : 21'sd0)) >>> 3;
		delta = clip_sym(quo, c);

		p0n = sx(p0) + delta;
		q0n = sx(q0) - delta;
		if (p0n < 0)
			p0c = '0;
		else if (p0n > sx(peak))
			p0c = peak;
		else
			p0c = p0n[PIX_W-1:0];
		if (q0n < 0)
			q0c = '0;
		else if (q0n > sx(peak))
			q0c = peak;
		else
			q0c = q0n[PIX_W-1:0];

		avg_sum = {1'b0, p0} + {1'b0, q0} + 17'd1;
		avg     = avg_sum[16:1];
		tp  = sx(p2) + sx(avg) - (sx(p1) <<< 1);
		tq  = sx(q2) + sx(avg) - (sx(q1) <<< 1);
		hp  = (tp + ((tp < 0) ? 21'sd1 : 21'sd0)) >>> 1;
		hq  = (tq + ((tq < 0) ? 21'sd1 : 21'sd0)) >>> 1;
		p1n = sx(p1) + clip_sym(hp, {1'b0, cfg.base_clip});
		q1n = sx(q1) + clip_sym(hq, {1'b0, cfg.base_clip});

		if (edge_ok) begin
			res.p1_out = (p_side ? p1n[PIX_W-1:0] : p1) & SAMPLE_MASK;
			res.p0_out = p0c & SAMPLE_MASK;
			res.q0_out = q0c & SAMPLE_MASK;
			res.q1_out = (q_side ? q1n[PIX_W-1:0] : q1) & SAMPLE_MASK;
			res.was_filtered = 1'b1;
		end else begin
			res.p1_out = p1;
			res.p0_out = p0;
			res.q0_out = q0;
			res.q1_out = q1;
			res.was_filtered = 1'b0;
		end
	end

endmodule

/* rtl/edge_deblock_line_filter_unit.sv */
// ---------------------------------------------------------------------------
// Edge deblocking line filter unit
// Two-register pipeline around the combinational line filter, with config regs.
// ---------------------------------------------------------------------------
// An accepted pixel beat passes through the input register, then the result register.
// Throughput: one line per cycle while flt_stall is low; the input register and
// the result register let a new beat enter while a finished result waits on flt_stall.
// Reset: arst_n clears both valid flags and loads the register defaults.
module edge_deblock_line_filter_unit import edbl_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  pix_line_t             pix,
	output logic                  flt_valid,
	input  logic                  flt_stall,
	output pix_result_t           flt,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	edbl_cfg_t   cfg;
	pix_line_t   line_s1;
	logic        valid_s1;
	pix_result_t res;
	pix_result_t flt_q;
	logic        flt_valid_q;
	logic        adv;
	logic        accept;

	edbl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	edbl_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_filter (
		.line (line_s1),
		.cfg  (cfg),
		.res  (res)
	);

	// The input stage moves on whenever the result register is free or being drained.
	assign adv       = valid_s1 && (!flt_valid_q || !flt_stall);
	assign pix_stall = valid_s1 && !adv;
	assign accept    = pix_valid && !pix_stall;
	assign flt_valid = flt_valid_q;
	assign flt       = flt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_s1 <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flt_valid_q <= 1'b0;
		end else if (adv) begin
			flt_valid_q <= 1'b1;
		end else if (!flt_stall) begin
			flt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flt_q <= res;
		end
	end

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel beat did not reach the input register");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && flt_valid_q && flt_stall |-> pix_stall)
		else $error("input taken while both stages are held");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !flt_valid_q |=> flt_valid_q)
		else $error("input stage failed to move into an empty result register");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> flt_q == $past(res))
		else $error("result register does not hold the filtered line");

endmodule
